/* rtl/gmms_pkg.sv */
`timescale 1ns / 1ps

package gmms_pkg;

    // Fixed field widths of the pixel stream
    localparam int PIXEL_W       = 16;
    localparam int STRETCH_W     = 8;
    localparam int GAIN_W        = 8;
    localparam int PIXEL_BITS_DEF = 16;

    // Numerator of the gain division and output ceiling
    localparam logic [GAIN_W-1:0] FULL_SCALE = 8'd255;

    // Restoring division: one quotient bit per step
    localparam int DIV_STEPS = GAIN_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Item operation codes
    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_APPLY   = 1'b1;

    typedef struct packed {
        logic               op;
        logic               frame_first;
        logic [PIXEL_W-1:0] pixel;
    } gmms_in_t;

    typedef struct packed {
        logic [STRETCH_W-1:0] stretched;
        logic                 flat;
    } gmms_out_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic measure;    // update min and max from the input pixel
        logic capture;    // hold the input pixel for the apply pass
        logic div_init;   // load divisor, clear remainder
        logic div_step;   // one restoring division step
        logic gain_load;  // take the quotient as the new gain
        logic gain_clear; // out-of-range span: gain is zero
        logic mul_out;    // form and register one result
    } gmms_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic span_ok;    // span lies in 1..FULL_SCALE
    } gmms_stat_t;

endpackage

/* rtl/grey_min_max_stretch.sv */
// Measure transfer: busy through setup, then an 8-step restoring divider (one gain
//   bit per cycle), or through setup alone if the span is 0 or >255.
// Apply transfer: busy in the multiplier state; the result strobe (done) is high for
//   one cycle, registered from that state. No new transfer is taken while busy.
// The receiver cannot stall: each result is valid only while done is high.
// Reset (rst_n low, asynchronous) clears minimum, maximum and gain to zero and idles.
`timescale 1ns / 1ps

module grey_min_max_stretch
    import gmms_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  gmms_in_t  item,
    output gmms_out_t result,
    output logic      done
);

    gmms_cmd_t  cmd;
    gmms_stat_t stat;

    gmms_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (item.op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    gmms_dpath #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result),
        .done   (done)
    );

    // One result per apply transfer: strobes never run back to back
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // The result strobe follows an apply transfer, through the multiplier state and the strobe register
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && item.op == OP_APPLY, 2))
        else $error("result without an apply transfer");

endmodule

/* rtl/gmms_ctrl.sv */
`timescale 1ns / 1ps

module gmms_ctrl
    import gmms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       op,
    input  gmms_stat_t stat,
    output gmms_cmd_t  cmd,
    output logic       busy
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SETUP = 4'b0010,
        S_DIV   = 4'b0100,
        S_MUL   = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   last_step;

    assign busy      = (state_reg != S_IDLE);
    assign last_step = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    // Sequence one transfer: measure goes through setup and, for an in-range span, divide; apply through multiply
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    if (op == OP_APPLY)
                    begin
                        state_next = S_MUL;
                    end
                    else
                    begin
                        cmd.measure = 1'b1;
                        state_next  = S_SETUP;
                    end
                end
            end
            S_SETUP:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                if (stat.span_ok)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    cmd.gain_clear = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (last_step)
                begin
                    cmd.gain_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_MUL:
            begin
                cmd.mul_out = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // A measure transfer always continues into the divider setup
    a_measure_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (start && state_reg == S_IDLE && op == OP_MEASURE) |=> state_reg == S_SETUP)
        else $error("measure transfer did not enter setup");

    // The gain is loaded only on the final division step
    a_gain_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.gain_load |-> (state_reg == S_DIV && last_step))
        else $error("gain loaded before division finished");

endmodule

/* rtl/gmms_dpath.sv */
`timescale 1ns / 1ps

module gmms_dpath
    import gmms_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  gmms_in_t   item,
    input  gmms_cmd_t  cmd,
    output gmms_stat_t stat,
    output gmms_out_t  result,
    output logic       done
);

    localparam int PROD_W = GAIN_W + PIXEL_BITS;

    logic [PIXEL_BITS-1:0] pix_in;
    logic [PIXEL_BITS-1:0] low_reg, low_next;
    logic [PIXEL_BITS-1:0] high_reg, high_next;
    logic [PIXEL_BITS-1:0] pix_reg;
    logic [PIXEL_BITS-1:0] span;
    logic [GAIN_W-1:0]     gain_reg;
    logic [GAIN_W-1:0]     divisor_reg;
    logic [GAIN_W-1:0]     rem_reg, rem_next;
    logic [GAIN_W-1:0]     quo_reg, quo_next;
    logic [GAIN_W:0]       trial;
    logic                  trial_ge;
    logic [PIXEL_BITS-1:0] diff;
    logic [PROD_W-1:0]     prod;
    logic                  is_flat;
    logic [STRETCH_W-1:0]  value;
    gmms_out_t             result_reg;
    logic                  done_reg;

    assign pix_in = item.pixel[PIXEL_BITS-1:0];

    // Running minimum and maximum; first pixel of a frame restarts both
    always_comb
    begin
        low_next  = low_reg;
        high_next = high_reg;
        if (item.frame_first)
        begin
            low_next  = pix_in;
            high_next = pix_in;
        end
        else
        begin
            if (pix_in < low_reg)
            begin
                low_next = pix_in;
            end
            if (pix_in > high_reg)
            begin
                high_next = pix_in;
            end
        end
    end

    // Span check: the division only runs for 1..FULL_SCALE
    assign span         = high_reg - low_reg;
    assign stat.span_ok = (span != '0) &&
                          ({1'b0, span} <= (PIXEL_BITS + 1)'(FULL_SCALE));

    // Restoring division step of FULL_SCALE by the span
    assign trial    = {rem_reg, quo_reg[GAIN_W-1]};
    assign trial_ge = (trial >= {1'b0, divisor_reg});
    always_comb
    begin
        if (trial_ge)
        begin
            rem_next = GAIN_W'(trial - {1'b0, divisor_reg});
        end
        else
        begin
            rem_next = trial[GAIN_W-1:0];
        end
        quo_next = {quo_reg[GAIN_W-2:0], trial_ge};
    end

    // Apply: gain times distance above the minimum, saturated
    assign is_flat = (high_reg == low_reg);
    assign diff    = pix_reg - low_reg;
    assign prod    = PROD_W'(gain_reg) * PROD_W'(diff);
    always_comb
    begin
        if (is_flat || pix_reg <= low_reg)
        begin
            value = '0;
        end
        else if (prod[PROD_W-1:STRETCH_W] != '0)
        begin
            value = FULL_SCALE;
        end
        else
        begin
            value = prod[STRETCH_W-1:0];
        end
    end

    // Frame levels and gain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= '0;
            high_reg <= '0;
            gain_reg <= '0;
        end
        else
        begin
            if (cmd.measure)
            begin
                low_reg  <= low_next;
                high_reg <= high_next;
            end
            if (cmd.gain_clear)
            begin
                gain_reg <= '0;
            end
            else if (cmd.gain_load)
            begin
                gain_reg <= quo_next;
            end
        end
    end

    // Divider, captured pixel and result register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pix_reg <= pix_in;
        end
        if (cmd.div_init)
        begin
            divisor_reg <= span[GAIN_W-1:0];
            rem_reg     <= '0;
            quo_reg     <= FULL_SCALE;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.mul_out)
        begin
            result_reg.stretched <= value;
            result_reg.flat      <= is_flat;
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.mul_out;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

    // Maximum never falls below minimum
    a_level_order: assert property (@(posedge clk) disable iff (!rst_n)
        high_reg >= low_reg)
        else $error("frame maximum below minimum");

    // A flat frame always gives a zero result
    a_flat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.flat) |-> result_reg.stretched == '0)
        else $error("flat frame gave nonzero result");

endmodule
